FILE: src/dqo_pkg.sv
// Shared types, constants and helper functions for the dual quadrature odometer.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
`default_nettype none

package dqo_pkg;

	// field widths
	localparam int CNT_W     = 32;   // position / window counters, speed results
	localparam int DIST_W    = 48;   // distance results
	localparam int CFG_W     = 16;   // wide configuration registers and period
	localparam int CFG_IDX_W = 3;    // configuration register index
	localparam int MS_W      = 10;   // width of the ms-per-second factor
	localparam int CIRCK_W   = CFG_W + MS_W;   // circumference times 1000
	localparam int DEN_W     = 2 * CFG_W;      // counts_per_rev times period
	localparam int NUM_W     = CNT_W + CIRCK_W; // widest dividend magnitude
	localparam int DCNT_W    = $clog2(NUM_W);  // divider step counter

	localparam logic [MS_W-1:0] MS_PER_S = MS_W'(1000);

	// configuration reset values
	localparam logic [CFG_W-1:0] CPR_RST  = CFG_W'(1320);
	localparam logic [CFG_W-1:0] CIRC_RST = CFG_W'(5228);
	localparam logic [CFG_W-1:0] DPER_RST = CFG_W'(10);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CPR   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_CIRC  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_LREV  = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_RREV  = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] CFG_DPER  = CFG_IDX_W'(4);

	// action codes
	localparam logic [1:0] ACT_UPDATE = 2'd0;
	localparam logic [1:0] ACT_SAMPLE = 2'd1;
	localparam logic [1:0] ACT_CLEAR  = 2'd2;

	typedef enum logic [1:0] {
		STEP_NONE = 2'b00,
		STEP_UP   = 2'b01,
		STEP_DN   = 2'b10
	} step_t;

	// the four divisions of one sample, in the order they run
	typedef enum logic [1:0] {
		OP_LSPD = 2'd0,
		OP_RSPD = 2'd1,
		OP_LDST = 2'd2,
		OP_RDST = 2'd3
	} op_t;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_PREP  = 6'b000010,
		S_LOAD  = 6'b000100,
		S_DIV   = 6'b001000,
		S_STORE = 6'b010000,
		S_FIN   = 6'b100000
	} state_t;

	typedef struct packed {
		logic upd;     // pin update transfer
		logic clr;     // clear transfer
		logic snap;    // sample transfer: capture and zero windows
		logic prep;    // form circumference*1000 and the speed divisor
		logic load;    // multiply and load the divider
		logic step;    // one divider step
		logic store;   // sign-correct and keep the quotient
		logic fin;     // form the vehicle distance
		op_t  op;
	} dqo_cmd_t;

	typedef struct packed {
		logic div_last;  // divider is on its final step
	} dqo_stat_t;

	// x4 decode: index is {previous phase, new phase}, phase is {A, B}
	function automatic step_t step_decode(input logic [3:0] idx);
		step_t s;
		unique case (idx) inside
			4'd2, 4'd4, 4'd11, 4'd13: s = STEP_UP;
			4'd1, 4'd7, 4'd8, 4'd14:  s = STEP_DN;
			default:                  s = STEP_NONE;
		endcase
		return s;
	endfunction

	// saturating increment / decrement of a signed counter
	function automatic logic signed [CNT_W-1:0] sat_step(
		input logic signed [CNT_W-1:0] v,
		input logic                    up,
		input logic                    dn
	);
		logic signed [CNT_W-1:0] r;
		r = v;
		if (up && (v != {1'b0, {(CNT_W-1){1'b1}}}))
			r = v + CNT_W'(1);
		else if (dn && (v != {1'b1, {(CNT_W-1){1'b0}}}))
			r = v - CNT_W'(1);
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] mag32(input logic signed [CNT_W-1:0] v);
		return v[CNT_W-1] ? (~v + CNT_W'(1)) : v;
	endfunction

endpackage

`default_nettype wire

FILE: src/dqo_ctrl.sv
// Controller: accepts items, sequences the four divisions of a sample and
// owns the result handshake. Depends on dqo_pkg.
`default_nettype none

module dqo_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           action,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output dqo_pkg::dqo_cmd_t         cmd,
	input  wire dqo_pkg::dqo_stat_t   stat
);

	dqo_pkg::state_t state_q;
	dqo_pkg::op_t    op_q;
	logic            out_valid_q;
	logic            acc;

	// a sample waits while the previous result is still unread
	assign in_stall = (state_q != dqo_pkg::S_IDLE) ||
	                  (out_valid_q && (action == dqo_pkg::ACT_SAMPLE));
	assign acc = in_valid && !in_stall;

	always_comb begin
		cmd       = '0;
		cmd.upd   = acc && (action == dqo_pkg::ACT_UPDATE);
		cmd.clr   = acc && (action == dqo_pkg::ACT_CLEAR);
		cmd.snap  = acc && (action == dqo_pkg::ACT_SAMPLE);
		cmd.prep  = (state_q == dqo_pkg::S_PREP);
		cmd.load  = (state_q == dqo_pkg::S_LOAD);
		cmd.step  = (state_q == dqo_pkg::S_DIV);
		cmd.store = (state_q == dqo_pkg::S_STORE);
		cmd.fin   = (state_q == dqo_pkg::S_FIN);
		cmd.op    = op_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dqo_pkg::S_IDLE;
			op_q        <= dqo_pkg::OP_LSPD;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				dqo_pkg::S_IDLE: begin
					if (cmd.snap) begin
						state_q <= dqo_pkg::S_PREP;
						op_q    <= dqo_pkg::OP_LSPD;
					end
				end
				dqo_pkg::S_PREP:  state_q <= dqo_pkg::S_LOAD;
				dqo_pkg::S_LOAD:  state_q <= dqo_pkg::S_DIV;
				dqo_pkg::S_DIV: begin
					if (stat.div_last)
						state_q <= dqo_pkg::S_STORE;
				end
				dqo_pkg::S_STORE: begin
					if (op_q == dqo_pkg::OP_RDST) begin
						state_q <= dqo_pkg::S_FIN;
					end else begin
						op_q    <= dqo_pkg::op_t'(op_q + 2'd1);
						state_q <= dqo_pkg::S_LOAD;
					end
				end
				dqo_pkg::S_FIN: begin
					state_q     <= dqo_pkg::S_IDLE;
					out_valid_q <= 1'b1;
				end
				default: state_q <= dqo_pkg::S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: src/dqo_datapath.sv
// Datapath: configuration registers, x4 decoders with saturating counters,
// sample snapshot, shared multiplier and a restoring bit-serial divider.
// Depends on dqo_pkg; driven by dqo_ctrl commands.
`default_nettype none

module dqo_datapath (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire dqo_pkg::dqo_cmd_t                     cmd,
	output dqo_pkg::dqo_stat_t                         stat,
	input  wire logic                                  cfg_we,
	input  wire logic [dqo_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [dqo_pkg::CFG_W-1:0]             cfg_data,
	input  wire logic                                  left_a,
	input  wire logic                                  left_b,
	input  wire logic                                  right_a,
	input  wire logic                                  right_b,
	input  wire logic [dqo_pkg::CFG_W-1:0]             period_ms,
	output logic signed [dqo_pkg::CNT_W-1:0]           left_pos,
	output logic signed [dqo_pkg::CNT_W-1:0]           right_pos,
	output logic signed [dqo_pkg::CNT_W-1:0]           left_delta,
	output logic signed [dqo_pkg::CNT_W-1:0]           right_delta,
	output logic signed [dqo_pkg::CNT_W-1:0]           left_speed_q8,
	output logic signed [dqo_pkg::CNT_W-1:0]           right_speed_q8,
	output logic signed [dqo_pkg::DIST_W-1:0]          left_dist_q8,
	output logic signed [dqo_pkg::DIST_W-1:0]          right_dist_q8,
	output logic signed [dqo_pkg::DIST_W-1:0]          vehicle_dist_q8,
	output logic [dqo_pkg::CFG_W-1:0]                  period_used,
	output logic                                       is_enabled
);

	localparam int CW  = dqo_pkg::CNT_W;
	localparam int DW  = dqo_pkg::DIST_W;
	localparam int FW  = dqo_pkg::CFG_W;
	localparam int NW  = dqo_pkg::NUM_W;
	localparam int QW  = dqo_pkg::DEN_W;

	// configuration
	logic [FW-1:0] cpr_q, circ_q, dper_q;
	logic          lrev_q, rrev_q;

	// counting state
	logic [1:0]           lph_q, rph_q;
	logic signed [CW-1:0] ltot_q, rtot_q, lwin_q, rwin_q;
	logic                 en_q;

	// sample snapshot
	logic signed [CW-1:0] ld_q, rd_q, lp_q, rp_q;
	logic [FW-1:0]        per_q;
	logic                 sen_q;

	// arithmetic
	logic [dqo_pkg::CIRCK_W-1:0] circk_q;
	logic [QW-1:0]               den_q;
	logic [NW-1:0]               num_q;
	logic [QW-1:0]               rem_q, dvs_q;
	logic                        neg_q;
	logic [dqo_pkg::DCNT_W-1:0]  dcnt_q;
	logic signed [CW-1:0]        lsp_q, rsp_q;
	logic signed [DW-1:0]        ldist_q, rdist_q, veh_q;

	logic [1:0]           lnow, rnow;
	dqo_pkg::step_t       lstep, rstep;
	logic                 lup, ldn, rup, rdn;
	logic [FW-1:0]        per_sel, cpr_eff;
	logic signed [CW-1:0] mul_v;
	logic [CW-1:0]        mul_a;
	logic [dqo_pkg::CIRCK_W-1:0] mul_b;
	logic [NW-1:0]        prod;
	logic [QW:0]          trial, diff;
	logic                 ge;
	logic signed [CW-1:0] spd_res;
	logic signed [DW-1:0] dst_res;
	logic signed [DW:0]   vsum, vadj;

	assign lnow = {left_a, left_b};
	assign rnow = {right_a, right_b};

	assign lstep = dqo_pkg::step_decode({lph_q, lnow});
	assign rstep = dqo_pkg::step_decode({rph_q, rnow});
	assign lup = lrev_q ? (lstep == dqo_pkg::STEP_DN) : (lstep == dqo_pkg::STEP_UP);
	assign ldn = lrev_q ? (lstep == dqo_pkg::STEP_UP) : (lstep == dqo_pkg::STEP_DN);
	assign rup = rrev_q ? (rstep == dqo_pkg::STEP_DN) : (rstep == dqo_pkg::STEP_UP);
	assign rdn = rrev_q ? (rstep == dqo_pkg::STEP_UP) : (rstep == dqo_pkg::STEP_DN);

	assign per_sel = (period_ms != '0) ? period_ms :
	                 (dper_q != '0)    ? dper_q    : FW'(1);
	assign cpr_eff = (cpr_q != '0) ? cpr_q : FW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpr_q  <= dqo_pkg::CPR_RST;
			circ_q <= dqo_pkg::CIRC_RST;
			lrev_q <= 1'b0;
			rrev_q <= 1'b0;
			dper_q <= dqo_pkg::DPER_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dqo_pkg::CFG_CPR:  cpr_q  <= cfg_data;
				dqo_pkg::CFG_CIRC: circ_q <= cfg_data;
				dqo_pkg::CFG_LREV: lrev_q <= cfg_data[0];
				dqo_pkg::CFG_RREV: rrev_q <= cfg_data[0];
				dqo_pkg::CFG_DPER: dper_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lph_q  <= '0;
			rph_q  <= '0;
			ltot_q <= '0;
			rtot_q <= '0;
			lwin_q <= '0;
			rwin_q <= '0;
			en_q   <= 1'b0;
		end else if (cmd.clr) begin
			lph_q  <= lnow;
			rph_q  <= rnow;
			ltot_q <= '0;
			rtot_q <= '0;
			lwin_q <= '0;
			rwin_q <= '0;
			en_q   <= 1'b1;
		end else if (cmd.upd && en_q) begin
			lph_q  <= lnow;
			rph_q  <= rnow;
			ltot_q <= dqo_pkg::sat_step(ltot_q, lup, ldn);
			lwin_q <= dqo_pkg::sat_step(lwin_q, lup, ldn);
			rtot_q <= dqo_pkg::sat_step(rtot_q, rup, rdn);
			rwin_q <= dqo_pkg::sat_step(rwin_q, rup, rdn);
		end else if (cmd.snap) begin
			lwin_q <= '0;
			rwin_q <= '0;
		end
	end

	// capture on the sample transfer; held until the next sample
	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			ld_q  <= lwin_q;
			rd_q  <= rwin_q;
			lp_q  <= ltot_q;
			rp_q  <= rtot_q;
			per_q <= per_sel;
			sen_q <= en_q;
		end
		if (cmd.prep) begin
			circk_q <= dqo_pkg::CIRCK_W'(circ_q) * dqo_pkg::CIRCK_W'(dqo_pkg::MS_PER_S);
			den_q   <= QW'(cpr_eff) * QW'(per_q);
		end
	end

	// shared multiplier: magnitude of the counter times the scale
	always_comb begin
		case (cmd.op)
			dqo_pkg::OP_LSPD: mul_v = ld_q;
			dqo_pkg::OP_RSPD: mul_v = rd_q;
			dqo_pkg::OP_LDST: mul_v = lp_q;
			default:          mul_v = rp_q;
		endcase
	end
	assign mul_a = dqo_pkg::mag32(mul_v);
	assign mul_b = (cmd.op == dqo_pkg::OP_LSPD || cmd.op == dqo_pkg::OP_RSPD) ?
	               circk_q : dqo_pkg::CIRCK_W'(circ_q);
	assign prod  = NW'(mul_a) * NW'(mul_b);

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, num_q[NW-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd.load) begin
			dcnt_q <= '0;
		end else if (cmd.step) begin
			dcnt_q <= dcnt_q + dqo_pkg::DCNT_W'(1);
		end
	end

	assign stat.div_last = (dcnt_q == dqo_pkg::DCNT_W'(NW - 1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			num_q <= prod;
			rem_q <= '0;
			neg_q <= mul_v[CW-1];
			dvs_q <= (cmd.op == dqo_pkg::OP_LSPD || cmd.op == dqo_pkg::OP_RSPD) ?
			         den_q : QW'(cpr_eff);
		end else if (cmd.step) begin
			num_q <= {num_q[NW-2:0], ge};
			rem_q <= ge ? diff[QW-1:0] : trial[QW-1:0];
		end
	end

	// sign-correct the quotient; speed saturates to 32 bits
	always_comb begin
		if (neg_q) begin
			if ((|num_q[NW-1:CW]) || (num_q[CW-1] && (|num_q[CW-2:0])))
				spd_res = {1'b1, {(CW-1){1'b0}}};
			else
				spd_res = ~num_q[CW-1:0] + CW'(1);
			dst_res = ~num_q[DW-1:0] + DW'(1);
		end else begin
			if (|num_q[NW-1:CW-1])
				spd_res = {1'b0, {(CW-1){1'b1}}};
			else
				spd_res = num_q[CW-1:0];
			dst_res = num_q[DW-1:0];
		end
	end

	// mean of both distances, truncated toward zero
	assign vsum = {ldist_q[DW-1], ldist_q} + {rdist_q[DW-1], rdist_q};
	assign vadj = vsum + (DW+1)'(vsum[DW]);

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			case (cmd.op)
				dqo_pkg::OP_LSPD: lsp_q   <= spd_res;
				dqo_pkg::OP_RSPD: rsp_q   <= spd_res;
				dqo_pkg::OP_LDST: ldist_q <= dst_res;
				default:          rdist_q <= dst_res;
			endcase
		end
		if (cmd.fin)
			veh_q <= vadj[DW:1];
	end

	assign left_pos        = lp_q;
	assign right_pos       = rp_q;
	assign left_delta      = ld_q;
	assign right_delta     = rd_q;
	assign left_speed_q8   = lsp_q;
	assign right_speed_q8  = rsp_q;
	assign left_dist_q8    = ldist_q;
	assign right_dist_q8   = rdist_q;
	assign vehicle_dist_q8 = veh_q;
	assign period_used     = per_q;
	assign is_enabled      = sen_q;

endmodule

`default_nettype wire

FILE: src/dual_quadrature_odometer_top.sv
// Pin update and clear items may follow back to back.
// A sample item runs four 58-step divisions through one shared restoring
// divider; input stalls until its result shows. A further sample also waits
// until the previous result is read.
// Reset (arst_n low, asynchronous) restores configuration defaults, zeroes the
// counters and phases, disables counting and drops any pending result.
`default_nettype none

module dual_quadrature_odometer_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire logic [1:0]                            action,
	input  wire logic                                  left_a,
	input  wire logic                                  left_b,
	input  wire logic                                  right_a,
	input  wire logic                                  right_b,
	input  wire logic [dqo_pkg::CFG_W-1:0]             period_ms,
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output logic signed [dqo_pkg::CNT_W-1:0]           left_pos,
	output logic signed [dqo_pkg::CNT_W-1:0]           right_pos,
	output logic signed [dqo_pkg::CNT_W-1:0]           left_delta,
	output logic signed [dqo_pkg::CNT_W-1:0]           right_delta,
	output logic signed [dqo_pkg::CNT_W-1:0]           left_speed_q8,
	output logic signed [dqo_pkg::CNT_W-1:0]           right_speed_q8,
	output logic signed [dqo_pkg::DIST_W-1:0]          left_dist_q8,
	output logic signed [dqo_pkg::DIST_W-1:0]          right_dist_q8,
	output logic signed [dqo_pkg::DIST_W-1:0]          vehicle_dist_q8,
	output logic [dqo_pkg::CFG_W-1:0]                  period_used,
	output logic                                       is_enabled,
	input  wire logic                                  cfg_valid,
	output logic                                       cfg_ready,
	input  wire logic [dqo_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [dqo_pkg::CFG_W-1:0]             cfg_data
);

	dqo_pkg::dqo_cmd_t  cmd;
	dqo_pkg::dqo_stat_t stat;

	assign cfg_ready = 1'b1;

	dqo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	dqo_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_valid && cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.left_a          (left_a),
		.left_b          (left_b),
		.right_a         (right_a),
		.right_b         (right_b),
		.period_ms       (period_ms),
		.left_pos        (left_pos),
		.right_pos       (right_pos),
		.left_delta      (left_delta),
		.right_delta     (right_delta),
		.left_speed_q8   (left_speed_q8),
		.right_speed_q8  (right_speed_q8),
		.left_dist_q8    (left_dist_q8),
		.right_dist_q8   (right_dist_q8),
		.vehicle_dist_q8 (vehicle_dist_q8),
		.period_used     (period_used),
		.is_enabled      (is_enabled)
	);

endmodule

`default_nettype wire

FILE: src/dqo_checker.sv
// Port-level checker for the odometer top level, attached by bind.
// Depends on dqo_pkg.
`default_nettype none

module dqo_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              in_valid,
	input wire logic                              in_stall,
	input wire logic [1:0]                        action,
	input wire logic                              out_valid,
	input wire logic                              out_stall,
	input wire logic signed [dqo_pkg::CNT_W-1:0]  left_pos,
	input wire logic signed [dqo_pkg::CNT_W-1:0]  right_pos,
	input wire logic signed [dqo_pkg::CNT_W-1:0]  left_delta,
	input wire logic signed [dqo_pkg::CNT_W-1:0]  right_delta,
	input wire logic [dqo_pkg::CFG_W-1:0]         period_used,
	input wire logic                              is_enabled
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(left_pos) && $stable(period_used))
		else $error("result changed while stalled");

	// a sample transfer makes the block busy with no result yet
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (action == dqo_pkg::ACT_SAMPLE) |=> in_stall && !out_valid)
		else $error("sample did not occupy the block");

	// a result only appears after a busy cycle
	a_rose_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without work");

	a_period: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (period_used != '0))
		else $error("zero period in result");

	// counters stay at zero until the first clear
	a_disabled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_enabled |-> (left_pos == '0) && (right_pos == '0) &&
			(left_delta == '0) && (right_delta == '0))
		else $error("counts moved before enable");

endmodule

bind dual_quadrature_odometer_top dqo_checker u_dqo_checker (.*);

`default_nettype wire
